FILE: design/lrfc_pkg.sv
// Shared types, codes, reset values and the CRC-32 byte step for the log record frame checker.
package lrfc_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_EXPECTED_MAGIC     = 2'd0;
    localparam logic [1:0] CFG_KEY_LENGTH_LIMIT   = 2'd1;
    localparam logic [1:0] CFG_VALUE_LENGTH_LIMIT = 2'd2;

    // Configuration reset values
    localparam logic [31:0] MAGIC_RESET       = 32'hABCD1234;
    localparam logic [15:0] KEY_LIMIT_RESET   = 16'd1024;
    localparam logic [23:0] VALUE_LIMIT_RESET = 24'd1048576;

    // Result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_RECORD  = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_TOO_SMALL = 2'd1;
    localparam logic [1:0] ERR_BAD_MAGIC = 2'd2;
    localparam logic [1:0] ERR_BAD_LENGTH = 2'd3;

    // Byte counter: wide enough for key plus value length within the limits
    localparam int COUNT_W = 25;
    localparam logic [COUNT_W-1:0] HEADER_BYTES      = 25'd8;
    localparam logic [COUNT_W-1:0] RECORD_HEAD_BYTES = 25'd13;
    localparam logic [COUNT_W-1:0] STORED_CRC_BYTES  = 25'd4;
    localparam logic [COUNT_W-1:0] TYPE_BYTE_POS     = 25'd4;
    localparam logic [COUNT_W-1:0] KEY_LEN_END       = 25'd9;

    localparam logic [47:0] FIRST_RECORD_OFFSET = 48'd8;
    localparam logic [31:0] CRC_POLY            = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT            = 32'hFFFFFFFF;

    localparam int RESULT_QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [31:0] expected_magic;
        logic [15:0] key_length_limit;
        logic [23:0] value_length_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [1:0]  error_code;
        logic [31:0] version;
        logic [47:0] record_offset;
        logic [7:0]  record_type;
        logic [31:0] key_length;
        logic [31:0] value_length;
        logic        crc_ok;
        logic [31:0] stored_checksum;
        logic [31:0] records_seen;
        logic [31:0] corrupt_seen;
        logic        last_of_run;
    } result_t;

    // Results produced by one byte, in order
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    // Reflected CRC-32 over one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        return (v == 32'hFFFFFFFF) ? v : v + 32'd1;
    endfunction

endpackage

FILE: design/lrfc_parser.sv
// Byte-level header and record deframer with running CRC-32; one byte per cycle.
module lrfc_parser (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic [7:0]      data_byte,
    input  logic            final_byte,
    input  lrfc_pkg::cfg_t  cfg,
    output lrfc_pkg::push_t push
);
    import lrfc_pkg::*;

    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_RECHEAD = 5'b00010,
        PH_BODY    = 5'b00100,
        PH_HALT    = 5'b01000,
        PH_DRAIN   = 5'b10000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] body_len_reg, body_len_next;
    logic [31:0]        header_reg, header_next;
    logic [31:0]        version_reg, version_next;
    logic [31:0]        stored_reg, stored_next;
    logic [31:0]        crc_reg, crc_next;
    logic [7:0]         type_reg, type_next;
    logic [31:0]        key_len_reg, key_len_next;
    logic [31:0]        value_len_reg, value_len_next;
    logic [47:0]        file_pos_reg, file_pos_next;
    logic [47:0]        rec_start_reg, rec_start_next;
    logic [31:0]        rec_total_reg, rec_total_next;
    logic [31:0]        corrupt_reg, corrupt_next;

    logic [31:0]        crc_step;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] body_sum;
    logic               finish;
    logic               crc_match;
    logic               main_valid;
    logic               fin_valid;
    result_t            main_res;
    result_t            fin_res;

    // Next-state and result logic for the byte at the input
    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        body_len_next  = body_len_reg;
        header_next    = header_reg;
        version_next   = version_reg;
        stored_next    = stored_reg;
        crc_next       = crc_reg;
        type_next      = type_reg;
        key_len_next   = key_len_reg;
        value_len_next = value_len_reg;
        file_pos_next  = file_pos_reg;
        rec_start_next = rec_start_reg;
        rec_total_next = rec_total_reg;
        corrupt_next   = corrupt_reg;
        main_valid     = 1'b0;
        main_res       = '0;
        fin_valid      = 1'b0;
        fin_res        = '0;
        finish         = 1'b0;
        crc_match      = 1'b0;
        crc_step       = crc32_byte(crc_reg, data_byte);
        count_inc      = count_reg + 25'd1;
        body_sum       = '0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                if (count_reg < STORED_CRC_BYTES)
                    header_next = {data_byte, header_reg[31:8]};
                else
                    version_next = {data_byte, version_reg[31:8]};
                count_next = count_inc;
                if (count_inc == HEADER_BYTES)
                begin
                    count_next = '0;
                    main_valid = 1'b1;
                    if (header_next != cfg.expected_magic)
                    begin
                        main_res.result_kind = KIND_ERROR;
                        main_res.error_code  = ERR_BAD_MAGIC;
                        phase_next           = PH_HALT;
                    end
                    else
                    begin
                        main_res.result_kind = KIND_HEADER;
                        main_res.version     = version_next;
                        phase_next           = PH_RECHEAD;
                    end
                end
            end
            PH_RECHEAD:
            begin
                if (count_reg < STORED_CRC_BYTES)
                    stored_next = {data_byte, stored_reg[31:8]};
                else
                begin
                    crc_next = crc_step;
                    if (count_reg == TYPE_BYTE_POS)
                        type_next = data_byte;
                    else if (count_reg < KEY_LEN_END)
                        key_len_next = {data_byte, key_len_reg[31:8]};
                    else
                        value_len_next = {data_byte, value_len_reg[31:8]};
                end
                count_next = count_inc;
                body_sum   = COUNT_W'(key_len_next[15:0]) + value_len_next[COUNT_W-1:0];
                if (count_inc == RECORD_HEAD_BYTES)
                begin
                    count_next = '0;
                    if (key_len_next > {16'd0, cfg.key_length_limit}
                        || value_len_next > {8'd0, cfg.value_length_limit})
                    begin
                        main_valid               = 1'b1;
                        main_res.result_kind     = KIND_ERROR;
                        main_res.error_code      = ERR_BAD_LENGTH;
                        main_res.record_offset   = rec_start_reg;
                        main_res.record_type     = type_next;
                        main_res.key_length      = key_len_next;
                        main_res.value_length    = value_len_next;
                        main_res.stored_checksum = stored_next;
                        phase_next               = PH_DRAIN;
                    end
                    else if (body_sum == '0)
                        finish = 1'b1;
                    else
                    begin
                        body_len_next = body_sum;
                        phase_next    = PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                crc_next   = crc_step;
                count_next = count_inc;
                if (count_inc >= body_len_reg)
                    finish = 1'b1;
            end
            PH_HALT, PH_DRAIN:
            begin
            end
            default:
            begin
            end
        endcase

        // Close a complete record
        if (finish)
        begin
            crc_match      = ((crc_next ^ CRC_INIT) == stored_next);
            rec_total_next = sat_inc32(rec_total_reg);
            if (!crc_match)
                corrupt_next = sat_inc32(corrupt_reg);
            main_valid               = 1'b1;
            main_res.result_kind     = KIND_RECORD;
            main_res.record_offset   = rec_start_reg;
            main_res.record_type     = type_next;
            main_res.key_length      = key_len_next;
            main_res.value_length    = value_len_next;
            main_res.crc_ok          = crc_match;
            main_res.stored_checksum = stored_next;
            main_res.records_seen    = rec_total_next;
            main_res.corrupt_seen    = corrupt_next;
            rec_start_next           = file_pos_reg + 48'd1;
            phase_next               = PH_RECHEAD;
            count_next               = '0;
            crc_next                 = CRC_INIT;
        end

        // End of file: report unless halted; return to the start-of-file state
        if (final_byte)
        begin
            if (phase_next == PH_HEADER)
            begin
                fin_valid           = 1'b1;
                fin_res.result_kind = KIND_ERROR;
                fin_res.error_code  = ERR_TOO_SMALL;
            end
            else if (phase_next != PH_HALT)
            begin
                fin_valid            = 1'b1;
                fin_res.result_kind  = KIND_SUMMARY;
                fin_res.records_seen = rec_total_next;
                fin_res.corrupt_seen = corrupt_next;
            end
            phase_next     = PH_HEADER;
            count_next     = '0;
            body_len_next  = '0;
            header_next    = '0;
            version_next   = '0;
            stored_next    = '0;
            crc_next       = CRC_INIT;
            type_next      = '0;
            key_len_next   = '0;
            value_len_next = '0;
            file_pos_next  = '0;
            rec_start_next = FIRST_RECORD_OFFSET;
            rec_total_next = '0;
            corrupt_next   = '0;
        end
        else
            file_pos_next = file_pos_reg + 48'd1;
    end

    // Order the results of this byte; the last one carries the run marker
    always_comb
    begin
        push = '0;
        if (in_fire)
        begin
            if (main_valid && fin_valid)
            begin
                push.count              = 2'd2;
                push.first              = main_res;
                push.second             = fin_res;
                push.second.last_of_run = 1'b1;
            end
            else if (main_valid)
            begin
                push.count             = 2'd1;
                push.first             = main_res;
                push.first.last_of_run = 1'b1;
            end
            else if (fin_valid)
            begin
                push.count             = 2'd1;
                push.first             = fin_res;
                push.first.last_of_run = 1'b1;
            end
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            count_reg     <= '0;
            body_len_reg  <= '0;
            header_reg    <= '0;
            version_reg   <= '0;
            stored_reg    <= '0;
            crc_reg       <= CRC_INIT;
            type_reg      <= '0;
            key_len_reg   <= '0;
            value_len_reg <= '0;
            file_pos_reg  <= '0;
            rec_start_reg <= FIRST_RECORD_OFFSET;
            rec_total_reg <= '0;
            corrupt_reg   <= '0;
        end
        else if (in_fire)
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            body_len_reg  <= body_len_next;
            header_reg    <= header_next;
            version_reg   <= version_next;
            stored_reg    <= stored_next;
            crc_reg       <= crc_next;
            type_reg      <= type_next;
            key_len_reg   <= key_len_next;
            value_len_reg <= value_len_next;
            file_pos_reg  <= file_pos_next;
            rec_start_reg <= rec_start_next;
            rec_total_reg <= rec_total_next;
            corrupt_reg   <= corrupt_next;
        end
    end

endmodule

FILE: design/lrfc_result_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per transaction.
module lrfc_result_fifo #(
    parameter int DEPTH = lrfc_pkg::RESULT_QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lrfc_pkg::push_t   push,
    output logic              room_low,
    output logic              out_valid,
    input  logic              out_stall,
    output lrfc_pkg::result_t out_res
);
    import lrfc_pkg::*;

    // DEPTH is a power of two, at least 2; pointers wrap naturally
    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(DEPTH - 2);

    result_t            entries_reg [DEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;
    logic [PTR_W-1:0]   wptr_plus1;

    assign out_valid  = (count_reg != '0);
    assign out_res    = entries_reg[rptr_reg];
    assign room_low   = (count_reg > ROOM_LIMIT);
    assign pop        = out_valid && !out_stall;
    assign wptr_plus1 = wptr_reg + PTR_W'(1);

    // Pointer and fill bookkeeping
    always_comb
    begin
        wptr_next  = wptr_reg + PTR_W'(push.count);
        rptr_next  = pop ? rptr_reg + PTR_W'(1) : rptr_reg;
        count_next = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Result storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entries_reg[wptr_reg] <= push.first;
        if (push.count == 2'd2)
            entries_reg[wptr_plus1] <= push.second;
    end

endmodule

FILE: design/log_record_frame_checker.sv
// Top level of the log record frame checker: configuration registers, parser and result queue.
//
// Takes a log file one byte per transaction (final_byte on the last byte), checks the 8-byte
// header and deframes length-prefixed records, checking each with CRC-32 (zlib). The results
// of each byte (at most two, only the final byte can give two) go into the result queue at
// the edge that accepts the byte. With the queue empty ahead of them, the first result is at
// the output the cycle after the byte is accepted and a second one follows once the first is
// taken. A new byte is accepted every cycle as long as the result queue has room for two
// results; in_stall rises only when the output side holds results back, so with out_stall
// low the rate is one byte per cycle.
// Configuration writes are always taken (cfg_ready is high) and apply from the next cycle.
module log_record_frame_checker #(
    parameter int RESULT_DEPTH = lrfc_pkg::RESULT_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [1:0]  error_code,
    output logic [31:0] version,
    output logic [47:0] record_offset,
    output logic [7:0]  record_type,
    output logic [31:0] key_length,
    output logic [31:0] value_length,
    output logic        crc_ok,
    output logic [31:0] stored_checksum,
    output logic [31:0] records_seen,
    output logic [31:0] corrupt_seen,
    output logic        last_of_run
);
    import lrfc_pkg::*;

    cfg_t    cfg_reg;
    push_t   push;
    result_t out_res;
    logic    room_low;
    logic    in_fire;

    assign cfg_ready = 1'b1;
    assign in_stall  = room_low;
    assign in_fire   = in_valid && !room_low;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_magic     <= MAGIC_RESET;
            cfg_reg.key_length_limit   <= KEY_LIMIT_RESET;
            cfg_reg.value_length_limit <= VALUE_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_EXPECTED_MAGIC:     cfg_reg.expected_magic     <= cfg_data;
                CFG_KEY_LENGTH_LIMIT:   cfg_reg.key_length_limit   <= cfg_data[15:0];
                CFG_VALUE_LENGTH_LIMIT: cfg_reg.value_length_limit <= cfg_data[23:0];
                default:
                begin
                end
            endcase
        end
    end

    lrfc_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .cfg        (cfg_reg),
        .push       (push)
    );

    lrfc_result_fifo #(
        .DEPTH (RESULT_DEPTH)
    ) u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room_low  (room_low),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    // Result fields
    assign result_kind     = out_res.result_kind;
    assign error_code      = out_res.error_code;
    assign version         = out_res.version;
    assign record_offset   = out_res.record_offset;
    assign record_type     = out_res.record_type;
    assign key_length      = out_res.key_length;
    assign value_length    = out_res.value_length;
    assign crc_ok          = out_res.crc_ok;
    assign stored_checksum = out_res.stored_checksum;
    assign records_seen    = out_res.records_seen;
    assign corrupt_seen    = out_res.corrupt_seen;
    assign last_of_run     = out_res.last_of_run;

endmodule

FILE: tb/sv/tb_log_record_frame_checker.sv
`timescale 1ns / 1ps
// Self-checking testbench for the log record frame checker: file stimulus and parse predictor.
module tb_log_record_frame_checker;
    import lrfc_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int PHASE_BYTES   = 475;
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic [4:0] {
        PH_HEADER   = 5'b00001,
        PH_REC_HEAD = 5'b00010,
        PH_BODY     = 5'b00100,
        PH_HALT     = 5'b01000,
        PH_DRAIN    = 5'b10000
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] value;
        logic       is_last;
        logic       hold;
    } file_byte_t;

    // DUT connections
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        final_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  result_kind;
    logic [1:0]  error_code;
    logic [31:0] version;
    logic [47:0] record_offset;
    logic [7:0]  record_type;
    logic [31:0] key_length;
    logic [31:0] value_length;
    logic        crc_ok;
    logic [31:0] stored_checksum;
    logic [31:0] records_seen;
    logic [31:0] corrupt_seen;
    logic        last_of_run;

    // Stimulus and scoreboard storage
    file_byte_t  pending_bytes [$];
    logic [7:0]  file_buf [$];
    result_t     expected_reports [$];
    int          bytes_queued = 0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;

    // Predictor copy of the registers
    logic [31:0] cfg_magic = MAGIC_RESET;
    logic [15:0] cfg_key_limit = KEY_LIMIT_RESET;
    logic [23:0] cfg_value_limit = VALUE_LIMIT_RESET;

    // Predictor copy of the parse state
    parse_phase_t phase;
    logic [31:0]  field_pos;
    logic [31:0]  magic_word;
    logic [31:0]  version_word;
    logic [31:0]  stored_crc;
    logic [31:0]  running_crc;
    logic [7:0]   rec_type;
    logic [31:0]  rec_key_len;
    logic [31:0]  rec_value_len;
    logic [47:0]  byte_offset;
    logic [47:0]  rec_offset;
    logic [31:0]  records_total;
    logic [31:0]  corrupt_total;
    result_t      step_out [2];
    int           step_n;

    log_record_frame_checker u_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Reflected CRC-32 update by one byte
    function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] r;
        r = acc ^ {24'h0, b};
        repeat (8)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic result_t blank_report(input logic [1:0] kind, input logic [1:0] code);
        result_t r;
        r = '0;
        r.result_kind = kind;
        r.error_code = code;
        return r;
    endfunction

    function automatic void emit_report(input result_t r);
        step_out[step_n] = r;
        step_n++;
    endfunction

    task automatic restart_file();
        phase = PH_HEADER;
        field_pos = '0;
        magic_word = '0;
        version_word = '0;
        stored_crc = '0;
        running_crc = '1;
        rec_type = '0;
        rec_key_len = '0;
        rec_value_len = '0;
        byte_offset = '0;
        rec_offset = FIRST_RECORD_OFFSET;
        records_total = '0;
        corrupt_total = '0;
    endtask

    // Complete record: CRC verdict, saturating counts, next record start
    task automatic close_record();
        result_t r;
        logic    match;
        match = (~running_crc == stored_crc);
        if (records_total != '1)
            records_total++;
        if (!match && corrupt_total != '1)
            corrupt_total++;
        r = blank_report(KIND_RECORD, ERR_NONE);
        r.record_offset = rec_offset;
        r.record_type = rec_type;
        r.key_length = rec_key_len;
        r.value_length = rec_value_len;
        r.crc_ok = match;
        r.stored_checksum = stored_crc;
        r.records_seen = records_total;
        r.corrupt_seen = corrupt_total;
        emit_report(r);
        rec_offset = byte_offset + 48'd1;
        phase = PH_REC_HEAD;
        field_pos = '0;
        running_crc = '1;
    endtask

    // Advance the parse state by one accepted byte and queue the reports it causes
    task automatic predict_frame_byte(input logic [7:0] b, input logic fin);
        result_t     r;
        logic [31:0] c;
        c = field_pos;
        step_n = 0;
        case (phase)
            PH_HEADER:
            begin
                if (c < 4)
                    magic_word = {b, magic_word[31:8]};
                else
                    version_word = {b, version_word[31:8]};
                field_pos = c + 1;
                if (field_pos == 8)
                begin
                    field_pos = '0;
                    if (magic_word != cfg_magic)
                    begin
                        emit_report(blank_report(KIND_ERROR, ERR_BAD_MAGIC));
                        phase = PH_HALT;
                    end
                    else
                    begin
                        r = blank_report(KIND_HEADER, ERR_NONE);
                        r.version = version_word;
                        emit_report(r);
                        phase = PH_REC_HEAD;
                    end
                end
            end
            PH_REC_HEAD:
            begin
                if (c < 4)
                    stored_crc = {b, stored_crc[31:8]};
                else
                begin
                    running_crc = crc_step(running_crc, b);
                    if (c == 4)
                        rec_type = b;
                    else if (c < 9)
                        rec_key_len = {b, rec_key_len[31:8]};
                    else
                        rec_value_len = {b, rec_value_len[31:8]};
                end
                field_pos = c + 1;
                if (field_pos == 13)
                begin
                    field_pos = '0;
                    if (rec_key_len > {16'h0, cfg_key_limit} ||
                        rec_value_len > {8'h0, cfg_value_limit})
                    begin
                        r = blank_report(KIND_ERROR, ERR_BAD_LENGTH);
                        r.record_offset = rec_offset;
                        r.record_type = rec_type;
                        r.key_length = rec_key_len;
                        r.value_length = rec_value_len;
                        r.stored_checksum = stored_crc;
                        emit_report(r);
                        phase = PH_DRAIN;
                    end
                    else if (rec_key_len + rec_value_len == 32'd0)
                        close_record();
                    else
                        phase = PH_BODY;
                end
            end
            PH_BODY:
            begin
                running_crc = crc_step(running_crc, b);
                field_pos = c + 1;
                if (field_pos >= rec_key_len + rec_value_len)
                    close_record();
            end
            default:
                ;
        endcase

        // End of file: too-small error or, unless halted, summary; then a fresh file
        if (fin)
        begin
            if (phase == PH_HEADER)
                emit_report(blank_report(KIND_ERROR, ERR_TOO_SMALL));
            else if (phase != PH_HALT)
            begin
                r = blank_report(KIND_SUMMARY, ERR_NONE);
                r.records_seen = records_total;
                r.corrupt_seen = corrupt_total;
                emit_report(r);
            end
            restart_file();
        end
        else
            byte_offset = byte_offset + 48'd1;

        if (step_n > 0)
            step_out[step_n - 1].last_of_run = 1'b1;
        for (int i = 0; i < step_n; i++)
            expected_reports.push_back(step_out[i]);
    endtask

    // Byte driver: predicts on acceptance, then loads the next pending byte or idles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_frame_byte(data_byte, final_byte);
            if (!in_valid || !in_stall)
            begin
                if (pending_bytes.size() > 0 &&
                    !(pending_bytes[0].hold && expected_reports.size() != 0) &&
                    $urandom_range(99) >= src_idle_pct)
                begin
                    in_valid <= 1'b1;
                    data_byte <= pending_bytes[0].value;
                    final_byte <= pending_bytes[0].is_last;
                    void'(pending_bytes.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Result monitor: checks each transaction against the oldest expectation
    always @(posedge clk)
    begin : report_monitor
        result_t want;
        result_t seen;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen = {result_kind, error_code, version, record_offset, record_type,
                        key_length, value_length, crc_ok, stored_checksum, records_seen,
                        corrupt_seen, last_of_run};
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got kind %0d code %0d",
                             $time, result_kind, error_code);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    compare_field("result_kind", 64'(want.result_kind),
                                  64'(seen.result_kind));
                    compare_field("error_code", 64'(want.error_code), 64'(seen.error_code));
                    compare_field("version", 64'(want.version), 64'(seen.version));
                    compare_field("record_offset", 64'(want.record_offset),
                                  64'(seen.record_offset));
                    compare_field("record_type", 64'(want.record_type),
                                  64'(seen.record_type));
                    compare_field("key_length", 64'(want.key_length), 64'(seen.key_length));
                    compare_field("value_length", 64'(want.value_length),
                                  64'(seen.value_length));
                    compare_field("crc_ok", 64'(want.crc_ok), 64'(seen.crc_ok));
                    compare_field("stored_checksum", 64'(want.stored_checksum),
                                  64'(seen.stored_checksum));
                    compare_field("records_seen", 64'(want.records_seen),
                                  64'(seen.records_seen));
                    compare_field("corrupt_seen", 64'(want.corrupt_seen),
                                  64'(seen.corrupt_seen));
                    compare_field("last_of_run", 64'(want.last_of_run),
                                  64'(seen.last_of_run));
                end
            end
            out_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // File building helpers
    task automatic add_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            file_buf.push_back(w[8*i +: 8]);
    endtask

    task automatic flush_file(input bit hold_first);
        file_byte_t fb;
        foreach (file_buf[i])
        begin
            fb.value = file_buf[i];
            fb.is_last = (i == file_buf.size() - 1);
            fb.hold = hold_first && (i == 0);
            pending_bytes.push_back(fb);
        end
        bytes_queued += file_buf.size();
        file_buf.delete();
    endtask

    // Record with its CRC over type, lengths and body; corrupt flips one CRC bit
    task automatic add_record(input logic [7:0] typ, input logic [31:0] klen,
                              input logic [31:0] vlen, input int body_len, input bit corrupt);
        logic [7:0]  covered [$];
        logic [31:0] crc;
        covered.push_back(typ);
        for (int i = 0; i < 4; i++)
            covered.push_back(klen[8*i +: 8]);
        for (int i = 0; i < 4; i++)
            covered.push_back(vlen[8*i +: 8]);
        repeat (body_len)
            covered.push_back(8'($urandom));
        crc = '1;
        foreach (covered[i])
            crc = crc_step(crc, covered[i]);
        crc = ~crc;
        if (corrupt)
            crc ^= 32'h1 << $urandom_range(31);
        add_word(crc);
        foreach (covered[i])
            file_buf.push_back(covered[i]);
    endtask

    // Mostly short lengths, occasionally longer, never above the limit
    function automatic logic [31:0] pick_length(input logic [31:0] limit);
        logic [31:0] cap;
        int          r;
        r = $urandom_range(99);
        if (r < 70)
            cap = 6;
        else if (r < 96)
            cap = 40;
        else
            cap = 300;
        if (r == 99 && limit <= 300)
            return limit;
        if (cap > limit)
            cap = limit;
        return $urandom_range(cap, 0);
    endfunction

    function automatic logic [31:0] pick_oversize(input logic [31:0] limit);
        case ($urandom_range(2))
            0: return limit + 1;
            1: return 32'hFFFF_FFFF;
            default: return limit + 1 + $urandom_range(1000);
        endcase
    endfunction

    // One random file: noise, short, bad magic, or a good header followed by records
    task automatic queue_random_file(input bit hold_first);
        int          shape;
        int          n_rec;
        int          sel;
        int          rec_len;
        int          keep;
        logic [31:0] klen;
        logic [31:0] vlen;
        logic [7:0]  typ;
        shape = $urandom_range(99);
        if (shape < 6)
            repeat ($urandom_range(24, 1)) file_buf.push_back(8'($urandom));
        else if (shape < 12)
            repeat ($urandom_range(7, 1)) file_buf.push_back(8'($urandom));
        else if (shape < 18)
        begin
            add_word(cfg_magic ^ (32'h1 << $urandom_range(31)));
            add_word($urandom);
            repeat ($urandom_range(12)) file_buf.push_back(8'($urandom));
        end
        else
        begin
            add_word(cfg_magic);
            add_word($urandom);
            n_rec = $urandom_range(4);
            for (int i = 0; i < n_rec; i++)
            begin
                typ = ($urandom_range(3) < 2) ? 8'($urandom_range(2, 1)) : 8'($urandom);
                if ($urandom_range(99) < 8)
                begin
                    // oversized length: rest of the file is ignored
                    sel = $urandom_range(2);
                    klen = (sel != 1) ? pick_oversize(32'(cfg_key_limit))
                                      : pick_length(32'(cfg_key_limit));
                    vlen = (sel != 0) ? pick_oversize(32'(cfg_value_limit))
                                      : pick_length(32'(cfg_value_limit));
                    add_record(typ, klen, vlen, $urandom_range(6), 1'($urandom_range(1)));
                    repeat ($urandom_range(8)) file_buf.push_back(8'($urandom));
                    break;
                end
                klen = pick_length(32'(cfg_key_limit));
                vlen = pick_length(32'(cfg_value_limit));
                add_record(typ, klen, vlen, int'(klen + vlen), $urandom_range(99) < 15);
                if (i == n_rec - 1 && $urandom_range(99) < 12)
                begin
                    // truncated trailing record
                    rec_len = 13 + klen + vlen;
                    keep = $urandom_range(rec_len - 1, 1);
                    repeat (rec_len - keep) void'(file_buf.pop_back());
                end
            end
        end
        flush_file(hold_first);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_EXPECTED_MAGIC:     cfg_magic = val;
            CFG_KEY_LENGTH_LIMIT:   cfg_key_limit = val[15:0];
            CFG_VALUE_LENGTH_LIMIT: cfg_value_limit = val[23:0];
            default:                ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_limits(input logic [31:0] magic, input logic [31:0] klim,
                              input logic [31:0] vlim);
        write_reg(CFG_EXPECTED_MAGIC, magic);
        write_reg(CFG_KEY_LENGTH_LIMIT, klim);
        write_reg(CFG_VALUE_LENGTH_LIMIT, vlim);
    endtask

    // Wait until the stream is empty and every expected result has arrived
    task automatic wait_quiet();
        do @(posedge clk);
        while (pending_bytes.size() != 0 || in_valid || expected_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int src_pct, input int snk_pct);
        int start;
        src_idle_pct = src_pct;
        sink_stall_pct = snk_pct;
        start = bytes_queued;
        queue_random_file(1'b1);
        while (bytes_queued - start < PHASE_BYTES)
            queue_random_file($urandom_range(99) < 4);
        wait_quiet();
    endtask

    // Main sequence
    initial
    begin
        restart_file();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: one-byte file, header ending the file, empty record ending the file
        file_buf.push_back(8'h00);
        flush_file(1'b0);
        add_word(cfg_magic);
        add_word(32'hFFFF_FFFF);
        flush_file(1'b1);
        add_word(cfg_magic);
        add_word(32'h0000_0000);
        add_record(8'hFF, 32'd0, 32'd0, 0, 1'b0);
        flush_file(1'b0);
        wait_quiet();

        // Random phases over register settings and flow control
        set_limits(32'hFFFF_FFFF, 32'd65535, 32'hFF_FFFF);
        run_phase(85, 0);
        set_limits(32'h0000_0000, 32'd0, 32'd0);
        run_phase(0, 85);
        set_limits($urandom, $urandom_range(40, 8), $urandom_range(60, 8));
        run_phase(29, 29);
        set_limits(MAGIC_RESET, KEY_LIMIT_RESET, VALUE_LIMIT_RESET);
        run_phase(0, 0);

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
